// ===== sv/ivfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivfp_pkg: shared types and constants
// Byte codes, field widths, the parser phase type and the result struct for the
// frame parser.
package ivfp_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 22;
  localparam int COUNT_W = 3;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] END_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] RADIX    = 8'd10;

  // Parser phase; code 2'd3 is never entered and behaves as hunting
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_ID     = 2'd1,
    PH_DIGITS = 2'd2
  } phase_t;

  // One completed frame
  typedef struct packed {
    logic [BYTE_W-1:0]  frame_id;
    logic [VALUE_W-1:0] frame_value;
  } result_t;

endpackage

// ===== sv/ivfp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivfp_in_stage: input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module ivfp_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ivfp_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                       consume,
  output logic                       byte_valid,
  output logic [ivfp_pkg::BYTE_W-1:0] byte_data
);
  import ivfp_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] data_r;
  logic              accept;

  // Stall only while a held beat cannot move on
  assign in_stall = valid_r && !consume;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

// ===== sv/ivfp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivfp_parser: frame state machine
// Hunts for the header, captures the id, accumulates digits, drops frames with
// too many digits and flags a nonzero-id frame at the terminator.
// ----------------------------------------------------------------------------
module ivfp_parser #(
  parameter int MAX_DIGITS = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ivfp_pkg::BYTE_W-1:0] byte_data,
  input  logic                        fire,
  output logic                        emit,
  output ivfp_pkg::result_t           result
);
  import ivfp_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  id_r, id_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [VALUE_W-1:0] mac;

  // value * 10 + byte, wraps at the field width
  assign mac = VALUE_W'(value_r * RADIX) + VALUE_W'(byte_data);

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    count_nxt = count_r;
    value_nxt = value_r;
    emit      = 1'b0;
    case (phase_r)
      PH_ID: begin
        id_nxt    = byte_data;
        count_nxt = '0;
        value_nxt = '0;
        phase_nxt = PH_DIGITS;
      end
      PH_DIGITS: begin
        if (byte_data == END_BYTE) begin
          emit      = (id_r != '0);
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          value_nxt = '0;
        end else if (count_r >= COUNT_W'(MAX_DIGITS)) begin
          // digit overflow: drop the frame
          phase_nxt = PH_HUNT;
          count_nxt = '0;
          value_nxt = '0;
        end else begin
          value_nxt = mac;
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      default: begin
        phase_nxt = (byte_data == HDR_BYTE) ? PH_ID : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      id_r    <= '0;
      count_r <= '0;
      value_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      count_r <= count_nxt;
      value_r <= value_nxt;
    end
  end

  assign result.frame_id    = id_r;
  assign result.frame_value = value_r;

endmodule

// ===== sv/ivfp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivfp_out_stage: result register
// Holds one completed frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module ivfp_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  ivfp_pkg::result_t            result,
  output logic                         slot_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ivfp_pkg::BYTE_W-1:0]  out_frame_id,
  output logic [ivfp_pkg::VALUE_W-1:0] out_frame_value
);
  import ivfp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  // Free when empty or the held beat leaves this cycle
  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid       = valid_r;
  assign out_frame_id    = data_r.frame_id;
  assign out_frame_value = data_r.frame_value;

endmodule

// ===== sv/id_value_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_value_frame_parser: header / id / decimal value frame parser
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_rx_byte[7:0]
//   out_     output     out_valid/out_stall out_frame_id[7:0], out_frame_value[21:0]
//
// One byte per cycle sustained while in_stall is low. A byte is registered in
// the input register on accept and parsed from there; a terminator that
// completes a frame is loaded into the result register, which drives
// out_valid. The digit multiply-add and state update are one short step
// between the input and result registers. Reset (synchronous, active low)
// empties both registers and returns to header hunting. in_stall rises only
// while a terminator beat waits behind a stalled result; other bytes keep flowing.
// ----------------------------------------------------------------------------
module id_value_frame_parser #(
  parameter int MAX_DIGITS = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ivfp_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ivfp_pkg::BYTE_W-1:0]  out_frame_id,
  output logic [ivfp_pkg::VALUE_W-1:0] out_frame_value
);
  import ivfp_pkg::*;

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_data;
  logic              fire;
  logic              emit;
  logic              slot_free;
  result_t           result;

  // Parse the held byte unless it finishes a frame with no room for it
  assign fire = byte_valid && (!emit || slot_free);

  ivfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .consume    (fire),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  ivfp_parser #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_data (byte_data),
    .fire      (fire),
    .emit      (emit),
    .result    (result)
  );

  ivfp_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire && emit),
    .result          (result),
    .slot_free       (slot_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_id    (out_frame_id),
    .out_frame_value (out_frame_value)
  );

endmodule
